/* src/dlsc_pkg.sv */
// Shared types and constants for the link symbol classifier.
`default_nettype none

package dlsc_pkg;

	// Field and register widths
	localparam int SYM_W      = 9;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 1;
	localparam int POS_W      = 16;
	localparam int PIX_NUM_W  = 20;
	localparam int COMP_W     = 2;
	localparam int CYC_W      = 32;
	localparam int SLOT_W     = 3;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 120;
	localparam int OUT_USER_W = 4;

	// Parameter defaults
	localparam int PIXEL_COUNT_BITS_DEF = 20;
	localparam int MN_BITS_DEF          = 24;

	// Configuration register reset values
	localparam logic [CFG_W-1:0] M_RESET = 24'd2200;
	localparam logic [CFG_W-1:0] N_RESET = 24'd4000;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_M_NUMERATOR   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_N_DENOMINATOR = 1'b1;

	// Control codes seen on lane 0
	localparam logic [SYM_W-1:0] K_FILL_START  = 9'h1FE;
	localparam logic [SYM_W-1:0] K_FILL_END    = 9'h1F7;
	localparam logic [SYM_W-1:0] K_BLANK_START = 9'h1BC;
	localparam logic [SYM_W-1:0] K_BLANK_END   = 9'h1FB;
	localparam logic [SYM_W-1:0] K_SEC_START   = 9'h15C;
	localparam logic [SYM_W-1:0] K_SEC_END     = 9'h1FD;

	// Slots after a blank start
	localparam logic [SLOT_W-1:0] SLOT_VBID_1 = 3'd6;
	localparam logic [SLOT_W-1:0] SLOT_MVID_1 = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_MAUD_1 = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_VBID_2 = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_MVID_2 = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_MAUD_2 = 3'd1;

	typedef enum logic [OUT_USER_W-1:0] {
		CLS_FILL_START  = 4'd0,
		CLS_FILL_END    = 4'd1,
		CLS_BLANK_START = 4'd2,
		CLS_BLANK_END   = 4'd3,
		CLS_SEC_START   = 4'd4,
		CLS_SEC_END     = 4'd5,
		CLS_FILL        = 4'd6,
		CLS_PIXEL       = 4'd7,
		CLS_SEC_DATA    = 4'd8,
		CLS_VBID        = 4'd9,
		CLS_MVID        = 4'd10,
		CLS_MAUD        = 4'd11,
		CLS_BLANKING    = 4'd12
	} sym_class_t;

	// Update strobes for the pixel counter
	typedef struct packed {
		logic inc;
		logic clr;
	} pix_ctl_t;

endpackage

`default_nettype wire

/* src/dp_link_symbol_classifier.sv */
// Top level of the two-lane link symbol classifier.
//
// Usage: one pair of lane symbols enters per word on the s_axis channel,
// lane 0 in tdata[8:0] and lane 1 in tdata[17:9]. Every word gives exactly one
// result word on m_axis: the symbol class in tuser and the counters, position,
// pixel number and M/N snapshot in tdata.
// The word is held in an input register, classified, and written into the
// result register. Throughput is one word per cycle while the receiver takes
// results, set by the single class-and-update stage.
// When the receiver stalls, the result register holds and the input register
// still takes one more word; then s_axis_tready drops until the result moves.
// Configuration writes on the cfg channel are always taken (cfg_ready is high)
// and load M (index 0) or N (index 1); the user must make them while no words
// are in flight; the block does not enforce this. Reset clears all counters,
// modes and both pipeline stages and loads M = 2200 and N = 4000.
`default_nettype none

module dp_link_symbol_classifier
	import dlsc_pkg::*;
#(
	parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF,
	parameter int MN_BITS          = MN_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// lane0_symbol, lane1_symbol, zero pad
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// line_position, pixel_number, colour_component, cycles_since_last,
	// blanking_flag, second_copy, m_count, m_fraction
	output logic      [OUT_DATA_W-1:0] m_axis_tdata,
	// symbol_class
	output logic      [OUT_USER_W-1:0] m_axis_tuser,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data
);

	// Configuration
	logic [CFG_W-1:0] m_q;
	logic [CFG_W-1:0] n_q;

	// Input stage
	logic             valid_s1;
	logic [SYM_W-1:0] lane0_s1;
	logic             lane1_b0_s1;

	// Result stage
	logic             valid_s2;
	sym_class_t       class_s2;
	logic [POS_W-1:0] pos_s2;
	logic [PIX_NUM_W-1:0] pnum_s2;
	logic [COMP_W-1:0] comp_s2;
	logic [CYC_W-1:0] since_s2;
	logic             bflag_s2;
	logic             second_s2;
	logic [CFG_W-1:0] mc_s2;
	logic [CFG_W-1:0] mf_s2;

	// Block state
	logic [CYC_W-1:0]  cyc_q;
	logic [CYC_W-1:0]  last_bs_q;
	logic [CYC_W-1:0]  last_be_q;
	logic              fill_mode_q;
	logic              pixel_mode_q;
	logic              sec_mode_q;
	logic [SLOT_W-1:0] slot_q;
	logic [POS_W-1:0]  pos_q;

	logic               advance;
	logic               in_fire;
	logic [MN_BITS-1:0] mn_count_nx;
	logic [MN_BITS-1:0] mn_fraction_nx;
	logic [PIX_NUM_W-1:0] pix_num;
	logic [COMP_W-1:0]  pix_comp;
	pix_ctl_t           pix_ctl;

	// Combinational results for the word in the input stage
	sym_class_t        cls;
	logic [PIX_NUM_W-1:0] pnum;
	logic [COMP_W-1:0] comp;
	logic [CYC_W-1:0]  since;
	logic              bflag;
	logic              second;
	logic [CFG_W-1:0]  mc;
	logic [CFG_W-1:0]  mf;
	logic              fill_mode_nx;
	logic              pixel_mode_nx;
	logic              sec_mode_nx;
	logic [SLOT_W-1:0] slot_nx;
	logic [POS_W-1:0]  pos_nx;
	logic              set_bs;
	logic              set_be;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= M_RESET;
			n_q <= N_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_M_NUMERATOR: begin
					m_q <= cfg_data;
				end
				REG_N_DENOMINATOR: begin
					n_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	dlsc_mn_accum #(
		.MN_BITS (MN_BITS)
	) u_mn_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.m_value     (m_q),
		.n_value     (n_q),
		.count_nx    (mn_count_nx),
		.fraction_nx (mn_fraction_nx)
	);

	dlsc_pix_cnt #(
		.PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
	) u_pix_cnt (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (pix_ctl),
		.pixel_number     (pix_num),
		.colour_component (pix_comp)
	);

	always_comb begin
		cls           = CLS_BLANKING;
		pnum          = '0;
		comp          = '0;
		since         = '0;
		bflag         = 1'b0;
		second        = 1'b0;
		mc            = '0;
		mf            = '0;
		fill_mode_nx  = fill_mode_q;
		pixel_mode_nx = pixel_mode_q;
		sec_mode_nx   = sec_mode_q;
		slot_nx       = slot_q;
		pos_nx        = pos_q + 1'b1;
		set_bs        = 1'b0;
		set_be        = 1'b0;
		pix_ctl.inc   = 1'b0;
		pix_ctl.clr   = 1'b0;

		if (lane0_s1 == K_FILL_START) begin
			cls          = CLS_FILL_START;
			fill_mode_nx = 1'b1;
		end else if (lane0_s1 == K_FILL_END) begin
			cls          = CLS_FILL_END;
			fill_mode_nx = 1'b0;
		end else if (lane0_s1 == K_BLANK_START) begin
			cls           = CLS_BLANK_START;
			since         = cyc_q - last_bs_q;
			pnum          = pix_num;
			comp          = pix_comp;
			mc            = CFG_W'(mn_count_nx);
			mf            = CFG_W'(mn_fraction_nx);
			slot_nx       = SLOT_VBID_1;
			pix_ctl.clr   = 1'b1;
			pixel_mode_nx = 1'b0;
			set_bs        = 1'b1;
		end else if (lane0_s1 == K_BLANK_END) begin
			cls           = CLS_BLANK_END;
			since         = cyc_q - last_be_q;
			pix_ctl.clr   = 1'b1;
			pos_nx        = '0;
			pixel_mode_nx = 1'b1;
			set_be        = 1'b1;
		end else if (lane0_s1 == K_SEC_START) begin
			cls         = CLS_SEC_START;
			sec_mode_nx = 1'b1;
		end else if (lane0_s1 == K_SEC_END) begin
			cls         = CLS_SEC_END;
			sec_mode_nx = 1'b0;
		end else if (fill_mode_q) begin
			cls = CLS_FILL;
		end else if (pixel_mode_q) begin
			cls         = CLS_PIXEL;
			pnum        = pix_num;
			comp        = pix_comp;
			pix_ctl.inc = 1'b1;
		end else if (sec_mode_q) begin
			cls = CLS_SEC_DATA;
		end else begin
			// Slots after a blank start: VB-ID, Mvid, Maud, then the second copies.
			case (slot_q)
				SLOT_VBID_1: begin
					cls   = CLS_VBID;
					bflag = lane0_s1[0];
				end
				SLOT_MVID_1: begin
					cls = CLS_MVID;
				end
				SLOT_MAUD_1: begin
					cls = CLS_MAUD;
				end
				SLOT_VBID_2: begin
					cls    = CLS_VBID;
					bflag  = lane1_b0_s1;
					second = 1'b1;
				end
				SLOT_MVID_2: begin
					cls    = CLS_MVID;
					second = 1'b1;
				end
				SLOT_MAUD_2: begin
					cls    = CLS_MAUD;
					second = 1'b1;
				end
				default: begin
					cls = CLS_BLANKING;
				end
			endcase
			if (cls != CLS_BLANKING) begin
				slot_nx = slot_q - 1'b1;
			end
		end

		if (!advance) begin
			pix_ctl.inc = 1'b0;
			pix_ctl.clr = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc_q        <= '0;
			last_bs_q    <= '0;
			last_be_q    <= '0;
			fill_mode_q  <= 1'b0;
			pixel_mode_q <= 1'b0;
			sec_mode_q   <= 1'b0;
			slot_q       <= '0;
			pos_q        <= '0;
		end else if (advance) begin
			cyc_q        <= cyc_q + 1'b1;
			fill_mode_q  <= fill_mode_nx;
			pixel_mode_q <= pixel_mode_nx;
			sec_mode_q   <= sec_mode_nx;
			slot_q       <= slot_nx;
			pos_q        <= pos_nx;
			if (set_bs) begin
				last_bs_q <= cyc_q;
			end
			if (set_be) begin
				last_be_q <= cyc_q;
			end
		end
	end

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			lane0_s1    <= s_axis_tdata[SYM_W-1:0];
			lane1_b0_s1 <= s_axis_tdata[SYM_W];
		end
		if (advance) begin
			class_s2  <= cls;
			pos_s2    <= pos_q;
			pnum_s2   <= pnum;
			comp_s2   <= comp;
			since_s2  <= since;
			bflag_s2  <= bflag;
			second_s2 <= second;
			mc_s2     <= mc;
			mf_s2     <= mf;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = class_s2;
	assign m_axis_tdata  = {mf_s2, mc_s2, second_s2, bflag_s2, since_s2,
		comp_s2, pnum_s2, pos_s2};

endmodule

`default_nettype wire

/* src/dlsc_mn_accum.sv */
// Running M/N accumulator: integer count and fraction advanced once per word.
`default_nettype none

module dlsc_mn_accum
	import dlsc_pkg::*;
#(
	parameter int MN_BITS = MN_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [CFG_W-1:0]   m_value,
	input  wire logic [CFG_W-1:0]   n_value,
	output logic      [MN_BITS-1:0] count_nx,
	output logic      [MN_BITS-1:0] fraction_nx
);

	localparam int SUM_W = ((MN_BITS > CFG_W) ? MN_BITS : CFG_W) + 1;

	logic [MN_BITS-1:0] count_q;
	logic [MN_BITS-1:0] fraction_q;
	logic [SUM_W-1:0]   sum;
	logic               wrap;
	logic [MN_BITS-1:0] count_inc;
	logic               count_ge;

	always_comb begin
		sum         = SUM_W'(fraction_q) + SUM_W'(m_value);
		wrap        = (sum >= SUM_W'(n_value));
		// Only one subtraction of N per word, even if the fraction stays above it.
		fraction_nx = wrap ? MN_BITS'(sum - SUM_W'(n_value)) : MN_BITS'(sum);
		count_inc   = wrap ? count_q + 1'b1 : count_q;
		count_ge    = (SUM_W'(count_inc) >= SUM_W'(m_value));
		count_nx    = count_ge ? MN_BITS'(SUM_W'(count_inc) - SUM_W'(m_value)) : count_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			fraction_q <= '0;
		end else if (step) begin
			count_q    <= count_nx;
			fraction_q <= fraction_nx;
		end
	end

endmodule

`default_nettype wire

/* src/dlsc_pix_cnt.sv */
// Pixel counter kept together with its quotient and remainder by three.
`default_nettype none

module dlsc_pix_cnt
	import dlsc_pkg::*;
#(
	parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pix_ctl_t              ctl,
	output logic      [PIX_NUM_W-1:0]  pixel_number,
	output logic      [COMP_W-1:0]     colour_component
);

	localparam logic [COMP_W-1:0] LAST_COMP = 2'd2;

	logic [PIXEL_COUNT_BITS-1:0] count_q;
	logic [PIXEL_COUNT_BITS-1:0] div3_q;
	logic [COMP_W-1:0]           mod3_q;

	// Two pixels go by for every three components.
	assign pixel_number     = PIX_NUM_W'({div3_q, 1'b0});
	assign colour_component = mod3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			div3_q  <= '0;
			mod3_q  <= '0;
		end else if (ctl.clr || (ctl.inc && (&count_q))) begin
			// Clearing and wrapping both restart the quotient and remainder.
			count_q <= '0;
			div3_q  <= '0;
			mod3_q  <= '0;
		end else if (ctl.inc) begin
			count_q <= count_q + 1'b1;
			if (mod3_q == LAST_COMP) begin
				mod3_q <= '0;
				div3_q <= div3_q + 1'b1;
			end else begin
				mod3_q <= mod3_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire
